@@ design/assert_macros.svh @@
// Assertion helpers for the LRU replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LRUPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lru replacement check failed");

// Checked on every clock edge, reset included.
`define LRUPR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lru replacement check failed");

`endif

@@ design/lrupr_pkg.sv @@
package lrupr_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int PAGE_BITS = 16;

  localparam int PAGE_PORT_W = 16;
  localparam int CFG_W       = 5;
  localparam int COUNT_W     = 32;

  localparam logic [CFG_W-1:0]   ACTIVE_SLOTS_RESET = CFG_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX          = '1;

  // Width that holds both the register value and the built slot count.
  localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int LIMIT_W    = (SLOT_CNT_W > CFG_W) ? SLOT_CNT_W : CFG_W;

  typedef logic [PAGE_BITS-1:0] page_t;

  // Per-cell controls for one transaction.
  typedef struct packed {
    logic take;    // transaction accepted this cycle
    logic clear;   // start of new workload
    logic hit;     // some in-use slot matched
    logic in_use;  // cell index below the slot limit
    logic is_top;  // most recent slot of the list
  } cell_ctrl_t;

endpackage

@@ design/lrupr_cell.sv @@
module lrupr_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  lrupr_pkg::cell_ctrl_t ctrl,
  input  lrupr_pkg::page_t      req_page,
  input  logic                  match_below,
  input  lrupr_pkg::page_t      page_up,
  input  logic                  valid_up,
  output logic                  match_out,
  output lrupr_pkg::page_t      page_dn,
  output logic                  valid_dn
);

  lrupr_pkg::page_t slot_page;
  lrupr_pkg::page_t slot_page_next;
  logic             slot_valid;
  logic             slot_valid_next;
  logic             hit_here;

  // A new workload wipes the slot before the compare.
  assign valid_dn  = slot_valid & ~ctrl.clear;
  assign page_dn   = ctrl.clear ? '0 : slot_page;
  assign hit_here  = ctrl.in_use & valid_dn & (page_dn == req_page);
  assign match_out = match_below | hit_here;

  always_comb begin
    slot_page_next  = page_dn;
    slot_valid_next = valid_dn;
    if (ctrl.in_use) begin
      if (ctrl.is_top) begin
        slot_page_next  = req_page;
        slot_valid_next = 1'b1;
      end else if (!ctrl.hit || match_out) begin
        // at or above the removed slot: move down one place
        slot_page_next  = page_up;
        slot_valid_next = valid_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (ctrl.take) begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      slot_page <= slot_page_next;
    end
  end

endmodule

@@ design/lru_page_replacement_top.sv @@
// Channel   Handshake                 Payload
// input     in_valid / in_ready       page, start_new
// output    out_valid / out_ready     was_hit, hit_total, access_total
// config    cfg_we (no wait)          cfg_wdata -> active_slots
//
// One transaction per cycle while in_ready is high: the compare across all slots, the list shift
// and the count update finish in the cycle of acceptance.
// The result register frees as it is read, so in_ready = !out_valid | out_ready.
// Reset (rst, synchronous): empty cache, counts zero, active_slots = 16.
// While out_valid is high and out_ready is low the result holds and no new input is taken.
`include "assert_macros.svh"

module lru_page_replacement_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [lrupr_pkg::PAGE_PORT_W-1:0]     page,
  input  logic                                  start_new,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  was_hit,
  output logic [lrupr_pkg::COUNT_W-1:0]         hit_total,
  output logic [lrupr_pkg::COUNT_W-1:0]         access_total,
  input  logic                                  cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int NS = lrupr_pkg::MAX_SLOTS;
  localparam int LW = lrupr_pkg::LIMIT_W;

  logic [lrupr_pkg::CFG_W-1:0]   active_slots;
  logic [LW-1:0]                 slot_limit;
  logic [LW-1:0]                 cfg_ext;
  logic                          take;
  logic                          hit;
  logic [31:0]                   page_ext;
  lrupr_pkg::page_t              req_page;
  logic [lrupr_pkg::COUNT_W-1:0] hit_base;
  logic [lrupr_pkg::COUNT_W-1:0] access_base;
  logic [lrupr_pkg::COUNT_W-1:0] hit_count_next;
  logic [lrupr_pkg::COUNT_W-1:0] access_count_next;

  // Chain wires: page and valid index k, match index k+1, carry what cell k hands on.
  logic [NS:0]           match_chain;
  lrupr_pkg::page_t      chain_page  [NS+1];
  logic [NS:0]           chain_valid;
  lrupr_pkg::cell_ctrl_t cell_ctrl   [NS];

  assign in_ready = ~out_valid | out_ready;
  assign take     = in_valid & in_ready;

  // Only the low PAGE_BITS of the port take part.
  assign page_ext = 32'(page);
  assign req_page = page_ext[lrupr_pkg::PAGE_BITS-1:0];

  // Effective slot count: zero reads as one, too large saturates.
  assign cfg_ext = LW'(active_slots);
  always_comb begin
    if (cfg_ext == '0) begin
      slot_limit = LW'(1);
    end else if (cfg_ext > LW'(NS)) begin
      slot_limit = LW'(NS);
    end else begin
      slot_limit = cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= lrupr_pkg::ACTIVE_SLOTS_RESET;
    end else if (cfg_we) begin
      active_slots <= cfg_wdata;
    end
  end

  // Oldest slot at index 0; the first match ripples upward through the chain.
  assign match_chain[0]  = 1'b0;
  assign chain_page[NS]  = '0;
  assign chain_valid[NS] = 1'b0;
  assign hit             = match_chain[NS];

  for (genvar k = 0; k < NS; k++) begin : g_cell
    assign cell_ctrl[k].take   = take;
    assign cell_ctrl[k].clear  = start_new;
    assign cell_ctrl[k].hit    = hit;
    assign cell_ctrl[k].in_use = (LW'(k) < slot_limit);
    assign cell_ctrl[k].is_top = (LW'(k + 1) == slot_limit);

    lrupr_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl[k]),
      .req_page    (req_page),
      .match_below (match_chain[k]),
      .page_up     (chain_page[k+1]),
      .valid_up    (chain_valid[k+1]),
      .match_out   (match_chain[k+1]),
      .page_dn     (chain_page[k]),
      .valid_dn    (chain_valid[k])
    );
  end

  // Saturating counts; a new workload restarts them before this access.
  assign hit_base    = start_new ? '0 : hit_total;
  assign access_base = start_new ? '0 : access_total;

  always_comb begin
    access_count_next = access_base;
    if (access_base != lrupr_pkg::COUNT_MAX) begin
      access_count_next = access_base + lrupr_pkg::COUNT_W'(1);
    end
    hit_count_next = hit_base;
    if (hit && (hit_base != lrupr_pkg::COUNT_MAX)) begin
      hit_count_next = hit_base + lrupr_pkg::COUNT_W'(1);
    end
  end

  // The count registers double as the result payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      was_hit      <= 1'b0;
      hit_total    <= '0;
      access_total <= '0;
    end else begin
      if (take) begin
        out_valid    <= 1'b1;
        was_hit      <= hit;
        hit_total    <= hit_count_next;
        access_total <= access_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LRUPR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)
  `LRUPR_ASSERT(a_hits_bounded, hit_total <= access_total)
  `LRUPR_ASSERT(a_access_step, (take && !start_new && access_total != lrupr_pkg::COUNT_MAX) |=> access_total == $past(access_total) + lrupr_pkg::COUNT_W'(1))
  `LRUPR_ASSERT(a_hit_step, (take && !start_new && hit_total != lrupr_pkg::COUNT_MAX) |=> was_hit == (hit_total != $past(hit_total)))
  `LRUPR_ASSERT(a_fresh_miss, (take && start_new) |=> !was_hit && access_total == lrupr_pkg::COUNT_W'(1))

endmodule
